### src/wst_pkg.sv
// Shared widths, field offsets, item kinds and control/status types for the sum tree selector.
package wst_pkg;

   // Field widths of one item
   localparam int KIND_BITS  = 2;
   localparam int INDEX_BITS = 10;
   localparam int RATE_BITS  = 32;
   localparam int SUM_BITS   = 42;
   localparam int COUNT_BITS = 11;

   // Request tdata layout: index, rate_value, search_key, zero pad
   localparam int REQ_INDEX_LSB = 0;
   localparam int REQ_RATE_LSB  = REQ_INDEX_LSB + INDEX_BITS;
   localparam int REQ_KEY_LSB   = REQ_RATE_LSB + RATE_BITS;
   localparam int REQ_DATA_BITS = 88;

   // Response tdata layout: total_sum, found_index, rate_out, zero pad
   localparam int RSP_TOTAL_LSB = 0;
   localparam int RSP_FOUND_LSB = RSP_TOTAL_LSB + SUM_BITS;
   localparam int RSP_RATE_LSB  = RSP_FOUND_LSB + INDEX_BITS;
   localparam int RSP_USED_BITS = RSP_RATE_LSB + RATE_BITS;
   localparam int RSP_DATA_BITS = 88;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_USED_BITS;

   // element_count after reset
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_SET    = 2'd0,
      KIND_TOTAL  = 2'd1,
      KIND_SEARCH = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   // How the current node pointer moves
   typedef enum logic [2:0] {
      NODE_HOLD,
      NODE_ROOT,
      NODE_LEFT,
      NODE_SIBLING,
      NODE_PARENT,
      NODE_LEAF_PARENT,
      NODE_STEP
   } node_op_type;

   // Which value the tree read port fetches
   typedef enum logic [2:0] {
      RD_NONE,
      RD_LEFT,
      RD_RIGHT,
      RD_INDEX,
      RD_NODE
   } read_sel_type;

   typedef struct packed {
      logic         load;
      logic         clr_step;
      logic         wr_leaf;
      logic         wr_sum;
      logic         set_dirty;
      logic         clr_dirty;
      logic         rd_dirty;
      logic         acc_load;
      logic         out_load;
      kind_type     out_kind;
      node_op_type  node_op;
      read_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic idx_live;
      logic dirty;
      logic is_root;
      logic is_left;
      logic kids_leaves;
   } status_type;

endpackage

### src/wst_datapath.sv
// Datapath: leaf, sum and dirty memories, node pointer, search key, adder and output registers.
module wst_datapath #(
   parameter int LEAF_SLOTS  = 1024,
   parameter int WEIGHT_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wst_pkg::cmd_type                    cmd,
   output wst_pkg::status_type                 stat,
   input  logic [wst_pkg::INDEX_BITS-1:0]      req_index,
   input  logic [wst_pkg::RATE_BITS-1:0]       req_rate,
   input  logic [wst_pkg::SUM_BITS-1:0]        req_key,
   input  logic                                csr_we,
   input  logic [wst_pkg::COUNT_BITS-1:0]      csr_data,
   output logic [wst_pkg::SUM_BITS-1:0]        out_total,
   output logic [wst_pkg::INDEX_BITS-1:0]      out_found,
   output logic [wst_pkg::RATE_BITS-1:0]       out_rate,
   output logic                                out_beyond
);

   localparam int LEAF_BITS  = $clog2(LEAF_SLOTS);
   localparam int NODE_W     = LEAF_BITS + 1;
   localparam int NODES      = LEAF_SLOTS - 1;
   localparam int STORE_BITS = (WEIGHT_BITS < wst_pkg::RATE_BITS) ? WEIGHT_BITS
                                                                  : wst_pkg::RATE_BITS;
   localparam int LIVE_W     = (NODE_W > wst_pkg::COUNT_BITS) ? NODE_W : wst_pkg::COUNT_BITS;

   // Configuration and item registers
   logic [wst_pkg::COUNT_BITS-1:0] count_ff;
   logic [wst_pkg::INDEX_BITS-1:0] idx_ff;
   logic [STORE_BITS-1:0]          rate_ff;
   logic [wst_pkg::SUM_BITS-1:0]   key_ff, key_in;
   logic [NODE_W-1:0]              cur_ff, cur_in;
   logic [wst_pkg::SUM_BITS-1:0]   acc_ff;
   logic [LEAF_BITS-1:0]           clr_ff;

   // Read data registers
   logic [STORE_BITS-1:0]          leaf_rd_ff;
   logic [wst_pkg::SUM_BITS-1:0]   sum_rd_ff;
   logic                           dirty_rd_ff;
   logic                           from_leaf_ff;
   logic                           zero_ff;

   // Output registers
   logic [wst_pkg::SUM_BITS-1:0]   total_ff, total_in;
   logic [wst_pkg::INDEX_BITS-1:0] found_ff, found_in;
   logic [wst_pkg::RATE_BITS-1:0]  rate_out_ff, rate_out_in;
   logic                           beyond_ff, beyond_in;

   // Memories
   logic [STORE_BITS-1:0]          leaf_mem  [LEAF_SLOTS];
   logic [wst_pkg::SUM_BITS-1:0]   sum_mem   [NODES];
   logic                           dirty_mem [NODES];

   logic [LIVE_W-1:0]              live;
   logic                           idx_live;
   logic [LEAF_BITS-1:0]           idx_leaf;
   logic [NODE_W-1:0]              left_node, right_node, child;
   logic                           child_is_leaf;
   logic [LEAF_BITS-1:0]           child_leaf;
   logic [NODE_W-1:0]              cur_leaf;
   logic [LEAF_BITS-1:0]           cur_addr;
   logic                           leaf_re, sum_re, leaf_zero;
   logic [LEAF_BITS-1:0]           leaf_raddr, sum_raddr;
   logic [wst_pkg::SUM_BITS-1:0]   child_val;
   logic                           go_left;

   // Effective count: element_count capped at the tree size
   assign live = (LIVE_W'(count_ff) < LIVE_W'(LEAF_SLOTS)) ? LIVE_W'(count_ff)
                                                            : LIVE_W'(LEAF_SLOTS);
   assign idx_live = LIVE_W'(idx_ff) < live;
   assign idx_leaf = LEAF_BITS'(idx_ff);

   // Tree navigation
   assign left_node     = (cur_ff << 1) + NODE_W'(1);
   assign right_node    = left_node + NODE_W'(1);
   assign child         = (cmd.rd_sel == wst_pkg::RD_RIGHT) ? right_node : left_node;
   assign child_is_leaf = child >= NODE_W'(NODES);
   assign child_leaf    = LEAF_BITS'(child - NODE_W'(NODES));
   assign cur_leaf      = cur_ff - NODE_W'(NODES);
   assign cur_addr      = LEAF_BITS'(cur_ff);

   // Read port steering
   always_comb begin
      leaf_re    = 1'b0;
      sum_re     = 1'b0;
      leaf_zero  = 1'b0;
      leaf_raddr = child_leaf;
      sum_raddr  = LEAF_BITS'(child);
      case (cmd.rd_sel)
         wst_pkg::RD_LEFT, wst_pkg::RD_RIGHT: begin
            if (child_is_leaf) begin
               leaf_re   = 1'b1;
               leaf_zero = LIVE_W'(child_leaf) >= live;
            end else begin
               sum_re = 1'b1;
            end
         end
         wst_pkg::RD_INDEX: begin
            leaf_re    = 1'b1;
            leaf_raddr = idx_leaf;
            leaf_zero  = !idx_live;
         end
         wst_pkg::RD_NODE: begin
            sum_re    = 1'b1;
            sum_raddr = cur_addr;
         end
         default: begin
            leaf_re = 1'b0;
         end
      endcase
   end

   // Value of the last child read; unused leaves read as zero
   assign child_val = from_leaf_ff ? (zero_ff ? '0 : wst_pkg::SUM_BITS'(leaf_rd_ff))
                                   : sum_rd_ff;
   assign go_left   = key_ff <= child_val;

   // Leaf weight memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         leaf_mem[clr_ff] <= '0;
      end else if (cmd.wr_leaf) begin
         leaf_mem[idx_leaf] <= rate_ff;
      end
      if (leaf_re) begin
         leaf_rd_ff <= leaf_mem[leaf_raddr];
      end
   end

   // Partial sum memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         if (clr_ff != LEAF_BITS'(NODES)) begin
            sum_mem[clr_ff] <= '0;
         end
      end else if (cmd.wr_sum) begin
         sum_mem[cur_addr] <= acc_ff + child_val;
      end
      if (sum_re) begin
         sum_rd_ff <= sum_mem[sum_raddr];
      end
   end

   // Dirty flag memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         if (clr_ff != LEAF_BITS'(NODES)) begin
            dirty_mem[clr_ff] <= 1'b0;
         end
      end else if (cmd.set_dirty) begin
         dirty_mem[cur_addr] <= 1'b1;
      end else if (cmd.clr_dirty) begin
         dirty_mem[cur_addr] <= 1'b0;
      end
      if (cmd.rd_dirty) begin
         dirty_rd_ff <= dirty_mem[cur_addr];
      end
   end

   // Node pointer and search key
   always_comb begin
      cur_in = cur_ff;
      key_in = key_ff;
      case (cmd.node_op)
         wst_pkg::NODE_ROOT:    cur_in = '0;
         wst_pkg::NODE_LEFT:    cur_in = left_node;
         wst_pkg::NODE_SIBLING: cur_in = cur_ff + NODE_W'(1);
         wst_pkg::NODE_PARENT:  cur_in = (cur_ff - NODE_W'(1)) >> 1;
         wst_pkg::NODE_LEAF_PARENT:
            cur_in = (NODE_W'(idx_leaf) + NODE_W'(NODES) - NODE_W'(1)) >> 1;
         wst_pkg::NODE_STEP: begin
            if (go_left) begin
               cur_in = left_node;
            end else begin
               cur_in = right_node;
               key_in = key_ff - child_val;
            end
         end
         default: cur_in = cur_ff;
      endcase
      if (cmd.load) begin
         key_in = req_key;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= wst_pkg::COUNT_RESET;
         clr_ff   <= '0;
      end else begin
         if (csr_we) begin
            count_ff <= csr_data;
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + LEAF_BITS'(1);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      key_ff <= key_in;
      if (cmd.load) begin
         idx_ff  <= req_index;
         rate_ff <= STORE_BITS'(req_rate);
      end
      if (cmd.acc_load) begin
         acc_ff <= child_val;
      end
      if (cmd.rd_sel != wst_pkg::RD_NONE) begin
         from_leaf_ff <= leaf_re;
         zero_ff      <= leaf_zero;
      end
   end

   // Result field values; fields the kind does not produce are zero
   always_comb begin
      total_in    = '0;
      found_in    = '0;
      rate_out_in = '0;
      beyond_in   = 1'b0;
      case (cmd.out_kind)
         wst_pkg::KIND_TOTAL:  total_in = child_val;
         wst_pkg::KIND_SEARCH: begin
            found_in  = wst_pkg::INDEX_BITS'(cur_leaf);
            beyond_in = LIVE_W'(cur_leaf) >= live;
         end
         wst_pkg::KIND_READ:   rate_out_in = wst_pkg::RATE_BITS'(child_val);
         default:              total_in = '0;
      endcase
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         total_ff    <= total_in;
         found_ff    <= found_in;
         rate_out_ff <= rate_out_in;
         beyond_ff   <= beyond_in;
      end
   end

   assign out_total  = total_ff;
   assign out_found  = found_ff;
   assign out_rate   = rate_out_ff;
   assign out_beyond = beyond_ff;

   // Status to the controller
   assign stat.clr_last    = clr_ff == LEAF_BITS'(NODES);
   assign stat.idx_live    = idx_live;
   assign stat.dirty       = dirty_rd_ff;
   assign stat.is_root     = cur_ff == '0;
   assign stat.is_left     = cur_ff[0];
   assign stat.kids_leaves = cur_ff >= NODE_W'(LEAF_SLOTS / 2 - 1);

endmodule

### src/wst_ctrl.sv
// Controller: sequences clearing, set weight, recompute, search and read weight over the datapath.
module wst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  wst_pkg::kind_type    req_kind,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output wst_pkg::cmd_type     cmd,
   input  wst_pkg::status_type  stat
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_LEAF,
      ST_SET_RD,
      ST_SET_CHK,
      ST_REC_RD,
      ST_REC_CHK,
      ST_REC_LEFT,
      ST_REC_RIGHT,
      ST_REC_WR,
      ST_REC_UP,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_READ_RD,
      ST_RESULT
   } state_type;

   state_type         state_ff, state_in;
   wst_pkg::kind_type kind_ff, kind_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.out_kind = kind_ff;
      cmd.node_op  = wst_pkg::NODE_HOLD;
      cmd.rd_sel   = wst_pkg::RD_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               kind_in  = req_kind;
               unique case (req_kind)
                  wst_pkg::KIND_SET: state_in = ST_SET_LEAF;
                  wst_pkg::KIND_TOTAL: begin
                     cmd.node_op = wst_pkg::NODE_ROOT;
                     state_in    = ST_REC_RD;
                  end
                  wst_pkg::KIND_SEARCH: begin
                     cmd.node_op = wst_pkg::NODE_ROOT;
                     state_in    = ST_SRCH_RD;
                  end
                  wst_pkg::KIND_READ: state_in = ST_READ_RD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         // Set weight: for a live index, write the leaf, then mark ancestors up to a dirty one or the root
         ST_SET_LEAF: begin
            if (stat.idx_live) begin
               cmd.wr_leaf = 1'b1;
               cmd.node_op = wst_pkg::NODE_LEAF_PARENT;
               state_in    = ST_SET_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SET_RD: begin
            cmd.rd_dirty = 1'b1;
            state_in     = ST_SET_CHK;
         end
         ST_SET_CHK: begin
            if (stat.dirty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.set_dirty = 1'b1;
               if (stat.is_root) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.node_op = wst_pkg::NODE_PARENT;
                  state_in    = ST_SET_RD;
               end
            end
         end
         // Recompute: post-order walk over dirty nodes
         ST_REC_RD: begin
            cmd.rd_dirty = 1'b1;
            state_in     = ST_REC_CHK;
         end
         ST_REC_CHK: begin
            if (!stat.dirty) begin
               state_in = ST_REC_UP;
            end else if (stat.kids_leaves) begin
               state_in = ST_REC_LEFT;
            end else begin
               cmd.node_op = wst_pkg::NODE_LEFT;
               state_in    = ST_REC_RD;
            end
         end
         ST_REC_LEFT: begin
            cmd.rd_sel = wst_pkg::RD_LEFT;
            state_in   = ST_REC_RIGHT;
         end
         ST_REC_RIGHT: begin
            cmd.acc_load = 1'b1;
            cmd.rd_sel   = wst_pkg::RD_RIGHT;
            state_in     = ST_REC_WR;
         end
         ST_REC_WR: begin
            cmd.wr_sum    = 1'b1;
            cmd.clr_dirty = 1'b1;
            state_in      = ST_REC_UP;
         end
         ST_REC_UP: begin
            if (stat.is_root) begin
               cmd.rd_sel = wst_pkg::RD_NODE;
               state_in   = ST_RESULT;
            end else if (stat.is_left) begin
               cmd.node_op = wst_pkg::NODE_SIBLING;
               state_in    = ST_REC_RD;
            end else begin
               cmd.node_op = wst_pkg::NODE_PARENT;
               state_in    = ST_REC_LEFT;
            end
         end
         // Search: read the left child, then compare and step down one level
         ST_SRCH_RD: begin
            cmd.rd_sel = wst_pkg::RD_LEFT;
            state_in   = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            cmd.node_op = wst_pkg::NODE_STEP;
            state_in    = stat.kids_leaves ? ST_RESULT : ST_SRCH_RD;
         end
         ST_READ_RD: begin
            cmd.rd_sel = wst_pkg::RD_INDEX;
            state_in   = ST_RESULT;
         end
         // Wait for the output register to free up
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= wst_pkg::KIND_SET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
      end
   end

endmodule

### src/weighted_sum_tree_selector_core.sv
// Top level of the weighted sum tree selector: stream ports, controller and datapath.
//
// Usage: items arrive on the req_ stream. req_tuser carries the kind (set weight,
// recompute total, search, read weight); req_tdata carries index, rate_value and
// search_key. Set weight gives no response; every other kind gives one item on the
// rsp_ stream with total_sum, found_index and rate_out in rsp_tdata and beyond_count
// in rsp_tuser. The csr_ port writes element_count; write it only while idle.
// One item is worked on at a time; the node memories have one read port each,
// so every tree level costs memory reads: search reads one child per level,
// set weight reads the dirty flag of each ancestor checked (none if the index
// is unused), and recompute total reads the flag of every node visited and both
// children of each dirty node. After reset a clearing pass zeroes the memories
// while req_tready stays low; csr writes are taken throughout. A result waits in
// the output register while rsp_tready is low; the next item is still accepted
// and runs until its own result is due, then holds until the register frees.
module weighted_sum_tree_selector_core #(
   parameter int LEAF_SLOTS  = 1024,
   parameter int WEIGHT_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // index, rate_value, search_key, zero pad
   input  logic [wst_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // kind
   input  logic [wst_pkg::KIND_BITS-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // total_sum, found_index, rate_out, zero pad
   output logic [wst_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // beyond_count
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wst_pkg::COUNT_BITS-1:0]      csr_data
);

   wst_pkg::cmd_type               cmd;
   wst_pkg::status_type            stat;
   logic [wst_pkg::SUM_BITS-1:0]   out_total;
   logic [wst_pkg::INDEX_BITS-1:0] out_found;
   logic [wst_pkg::RATE_BITS-1:0]  out_rate;
   logic                           out_beyond;

   assign csr_ready = 1'b1;

   wst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (wst_pkg::kind_type'(req_tuser)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   wst_datapath #(
      .LEAF_SLOTS  (LEAF_SLOTS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_index  (req_tdata[wst_pkg::REQ_INDEX_LSB +: wst_pkg::INDEX_BITS]),
      .req_rate   (req_tdata[wst_pkg::REQ_RATE_LSB +: wst_pkg::RATE_BITS]),
      .req_key    (req_tdata[wst_pkg::REQ_KEY_LSB +: wst_pkg::SUM_BITS]),
      .csr_we     (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .out_total  (out_total),
      .out_found  (out_found),
      .out_rate   (out_rate),
      .out_beyond (out_beyond)
   );

   assign rsp_tdata = {{wst_pkg::RSP_PAD_BITS{1'b0}}, out_rate, out_found, out_total};
   assign rsp_tuser = out_beyond;

endmodule

### src/wst_checker.sv
// Port-level checks for the sum tree selector, bound to the top level.
module wst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [wst_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [0:0]                        rsp_tuser
);

   logic [wst_pkg::SUM_BITS-1:0]   total_f;
   logic [wst_pkg::INDEX_BITS-1:0] found_f;
   logic [wst_pkg::RATE_BITS-1:0]  rate_f;

   assign total_f = rsp_tdata[wst_pkg::RSP_TOTAL_LSB +: wst_pkg::SUM_BITS];
   assign found_f = rsp_tdata[wst_pkg::RSP_FOUND_LSB +: wst_pkg::INDEX_BITS];
   assign rate_f  = rsp_tdata[wst_pkg::RSP_RATE_LSB +: wst_pkg::RATE_BITS];

   // Clearing pass blocks items right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("item accepted during clearing pass");

   // Items are taken one at a time: req_tready drops once an item is accepted
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back item accepted");

   // A flagged search result carries no sum and no weight
   a_beyond_is_search: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> total_f == '0 && rate_f == '0)
      else $error("beyond_count on a non-search result");

   // A read weight result carries nothing else
   a_rate_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rate_f != '0 |-> total_f == '0 && found_f == '0 && !rsp_tuser[0])
      else $error("read weight result mixed with other fields");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind weighted_sum_tree_selector_core wst_checker u_wst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/weighted_sum_tree_selector_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the weighted sum tree selector: mirrored tree, stream drivers.
module weighted_sum_tree_selector_core_test;

   localparam int LEAVES        = 1024;
   localparam int NODES         = LEAVES - 1;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [wst_pkg::SUM_BITS-1:0]   total;
      logic [wst_pkg::INDEX_BITS-1:0] found;
      logic [wst_pkg::RATE_BITS-1:0]  rate;
      logic                           beyond;
   } tree_result_type;

   // Mirror of the weight tree; predicts each result and matches what comes back
   class sum_tree_mirror;
      logic [wst_pkg::RATE_BITS-1:0]  weight_mem [LEAVES];
      logic [wst_pkg::SUM_BITS-1:0]   sum_mem [NODES];
      bit                             dirty_mem [NODES];
      logic [wst_pkg::COUNT_BITS-1:0] count;
      tree_result_type                pending_results [$];
      int                             errors;

      function new();
         foreach (weight_mem[i]) weight_mem[i] = '0;
         foreach (sum_mem[i]) sum_mem[i] = '0;
         foreach (dirty_mem[i]) dirty_mem[i] = 1'b0;
         count  = wst_pkg::COUNT_RESET;
         errors = 0;
      endfunction

      function int live();
         return (count < LEAVES) ? int'(count) : LEAVES;
      endfunction

      function logic [wst_pkg::SUM_BITS-1:0] node_val(int n);
         if (n < NODES) return sum_mem[n];
         if (n - NODES >= live()) return '0;
         return wst_pkg::SUM_BITS'(weight_mem[n - NODES]);
      endfunction

      // Update the tree for one accepted item and queue its result, if any
      function void apply_item(wst_pkg::kind_type kind,
                               logic [wst_pkg::INDEX_BITS-1:0] idx,
                               logic [wst_pkg::RATE_BITS-1:0] rate,
                               logic [wst_pkg::SUM_BITS-1:0] key);
         tree_result_type              want;
         int                           n;
         int                           left;
         logic [wst_pkg::SUM_BITS-1:0] rest;
         logic [wst_pkg::SUM_BITS-1:0] ls;
         want = '0;
         case (kind)
            wst_pkg::KIND_SET: begin
               if (int'(idx) >= live()) return;
               weight_mem[idx] = rate;
               n = (int'(idx) + NODES - 1) / 2;
               while (!dirty_mem[n]) begin
                  dirty_mem[n] = 1'b1;
                  if (n == 0) break;
                  n = (n - 1) / 2;
               end
               return;
            end
            wst_pkg::KIND_TOTAL: begin
               // children carry higher numbers, so a downward sweep is bottom-up
               for (n = NODES - 1; n >= 0; n--) begin
                  if (dirty_mem[n]) begin
                     sum_mem[n]   = node_val(2 * n + 1) + node_val(2 * n + 2);
                     dirty_mem[n] = 1'b0;
                  end
               end
               want.total = sum_mem[0];
            end
            wst_pkg::KIND_SEARCH: begin
               n    = 0;
               rest = key;
               while (n < NODES) begin
                  left = 2 * n + 1;
                  ls   = node_val(left);
                  if (rest <= ls) begin
                     n = left;
                  end else begin
                     rest = rest - ls;
                     n    = left + 1;
                  end
               end
               want.found  = wst_pkg::INDEX_BITS'(n - NODES);
               want.beyond = (n - NODES >= live());
            end
            default: begin
               want.rate = (int'(idx) >= live()) ? '0 : weight_mem[idx];
            end
         endcase
         pending_results = {pending_results, want};
      endfunction

      function void check_result(tree_result_type got);
         tree_result_type want;
         if (pending_results.size() == 0) begin
            $error("result with none outstanding: total_sum %0h found_index %0d rate_out %0h",
                   got.total, got.found, got.rate);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.total !== want.total) begin
            $error("total_sum: expected %0h, got %0h", want.total, got.total);
            errors++;
         end
         if (got.found !== want.found) begin
            $error("found_index: expected %0d, got %0d", want.found, got.found);
            errors++;
         end
         if (got.rate !== want.rate) begin
            $error("rate_out: expected %0h, got %0h", want.rate, got.rate);
            errors++;
         end
         if (got.beyond !== want.beyond) begin
            $error("beyond_count: expected %0b, got %0b", want.beyond, got.beyond);
            errors++;
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [wst_pkg::REQ_DATA_BITS-1:0]   req_tdata = '0;
   logic [wst_pkg::KIND_BITS-1:0]       req_tuser = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [wst_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;
   logic [0:0]                          rsp_tuser;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [wst_pkg::COUNT_BITS-1:0]      csr_data = '0;

   sum_tree_mirror mirror;
   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_ask  = 0;
   int hold_seen = 0;
   int hold_left = 0;

   weighted_sum_tree_selector_core #(
      .LEAF_SLOTS (LEAVES),
      .WEIGHT_BITS(32)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

   // Watch all three channels at the rising edge
   always @(posedge clock) begin
      tree_result_type got;
      if (!reset && mirror != null) begin
         if (csr_valid && csr_ready) mirror.count = csr_data;
         if (req_tvalid && req_tready)
            mirror.apply_item(wst_pkg::kind_type'(req_tuser),
                              req_tdata[wst_pkg::REQ_INDEX_LSB +: wst_pkg::INDEX_BITS],
                              req_tdata[wst_pkg::REQ_RATE_LSB +: wst_pkg::RATE_BITS],
                              req_tdata[wst_pkg::REQ_KEY_LSB +: wst_pkg::SUM_BITS]);
         if (rsp_tvalid && rsp_tready) begin
            got.total  = rsp_tdata[wst_pkg::RSP_TOTAL_LSB +: wst_pkg::SUM_BITS];
            got.found  = rsp_tdata[wst_pkg::RSP_FOUND_LSB +: wst_pkg::INDEX_BITS];
            got.rate   = rsp_tdata[wst_pkg::RSP_RATE_LSB +: wst_pkg::RATE_BITS];
            got.beyond = rsp_tuser[0];
            mirror.check_result(got);
         end
      end
   end

   // Result side: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offer one item; entered and left just after a falling edge
   task automatic send_item(input wst_pkg::kind_type kind,
                            input logic [wst_pkg::INDEX_BITS-1:0] idx,
                            input logic [wst_pkg::RATE_BITS-1:0] rate,
                            input logic [wst_pkg::SUM_BITS-1:0] key);
      logic [wst_pkg::REQ_DATA_BITS-1:0] word;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      word = '0;
      word[wst_pkg::REQ_INDEX_LSB +: wst_pkg::INDEX_BITS] = idx;
      word[wst_pkg::REQ_RATE_LSB +: wst_pkg::RATE_BITS]   = rate;
      word[wst_pkg::REQ_KEY_LSB +: wst_pkg::SUM_BITS]     = key;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_count(input logic [wst_pkg::COUNT_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop sending, collect every outstanding result, then let a set weight finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (mirror.pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_item();
      int                             pick;
      int                             span;
      logic [wst_pkg::INDEX_BITS-1:0] idx;
      logic [wst_pkg::RATE_BITS-1:0]  rate;
      logic [wst_pkg::SUM_BITS-1:0]   key;
      logic [wst_pkg::SUM_BITS-1:0]   root;
      logic [63:0]                    wide;
      wst_pkg::kind_type              kind;
      span = mirror.live();
      root = mirror.sum_mem[0];
      pick = $urandom_range(99);
      kind = (pick < 45) ? wst_pkg::KIND_SET : (pick < 55) ? wst_pkg::KIND_TOTAL :
             (pick < 85) ? wst_pkg::KIND_SEARCH : wst_pkg::KIND_READ;
      // mostly live leaves, some beyond the count
      if (span > 0 && $urandom_range(99) < 80)
         idx = wst_pkg::INDEX_BITS'($urandom_range(span - 1));
      else
         idx = wst_pkg::INDEX_BITS'($urandom_range(LEAVES - 1));
      pick = $urandom_range(9);
      if (pick == 0) rate = '0;
      else if (pick == 1) rate = '1;
      else if (pick < 4) rate = wst_pkg::RATE_BITS'($urandom_range(255));
      else rate = wst_pkg::RATE_BITS'($urandom);
      wide = {$urandom, $urandom};
      pick = $urandom_range(9);
      case (pick)
         0:       key = '0;
         1:       key = root;
         2:       key = root + 1'b1;
         3:       key = wide[wst_pkg::SUM_BITS-1:0];
         default: key = wst_pkg::SUM_BITS'(wide % (64'(root) + 64'd1));
      endcase
      send_item(kind, idx, rate, key);
   endtask

   task automatic run_phase(input logic [wst_pkg::COUNT_BITS-1:0] count, input int idle,
                            input int stall, input int items, input bit hold);
      settle();
      write_count(count);
      idle_pct  = idle;
      stall_pct = stall;
      if (hold) hold_ask++;
      repeat (items) send_random_item();
   endtask

   initial begin
      mirror = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // csr is taken during the clearing pass
      write_count(wst_pkg::COUNT_RESET);

      // Empty tree, then extremes of weight and key
      send_item(wst_pkg::KIND_READ, 10'd0, '0, '0);
      send_item(wst_pkg::KIND_READ, 10'd1023, '0, '0);
      send_item(wst_pkg::KIND_TOTAL, '0, '0, '0);
      send_item(wst_pkg::KIND_SEARCH, '0, '0, '0);
      send_item(wst_pkg::KIND_SEARCH, '0, '0, '1);
      send_item(wst_pkg::KIND_SET, 10'd0, '1, '0);
      send_item(wst_pkg::KIND_SET, 10'd1023, '1, '0);
      send_item(wst_pkg::KIND_SET, 10'd512, 32'd1, '0);
      send_item(wst_pkg::KIND_SET, 10'd1, '0, '0);
      // search before recompute sees the old sums
      send_item(wst_pkg::KIND_SEARCH, '0, '0, 42'd5);
      send_item(wst_pkg::KIND_TOTAL, '0, '0, '0);
      send_item(wst_pkg::KIND_SEARCH, '0, '0, '0);
      send_item(wst_pkg::KIND_SEARCH, '0, '0, 42'hFFFF_FFFF);
      send_item(wst_pkg::KIND_SEARCH, '0, '0, 42'h1_0000_0000);
      send_item(wst_pkg::KIND_SEARCH, '0, '0, mirror.sum_mem[0]);
      send_item(wst_pkg::KIND_SEARCH, '0, '0, mirror.sum_mem[0] + 1'b1);
      send_item(wst_pkg::KIND_READ, 10'd0, '0, '0);
      send_item(wst_pkg::KIND_READ, 10'd512, '0, '0);

      // Small count: sets and reads beyond it, old sums kept until dirtied
      settle();
      write_count(11'd3);
      send_item(wst_pkg::KIND_SET, 10'd2, 32'd7, '0);
      send_item(wst_pkg::KIND_SET, 10'd10, 32'd5, '0);
      send_item(wst_pkg::KIND_READ, 10'd1023, '0, '0);
      send_item(wst_pkg::KIND_TOTAL, '0, '0, '0);
      send_item(wst_pkg::KIND_SEARCH, '0, '0, '1);

      // Zero count: every set ignored, every leaf zero
      settle();
      write_count(11'd0);
      send_item(wst_pkg::KIND_SET, 10'd0, 32'd9, '0);
      send_item(wst_pkg::KIND_READ, 10'd0, '0, '0);
      send_item(wst_pkg::KIND_TOTAL, '0, '0, '0);
      send_item(wst_pkg::KIND_SEARCH, '0, '0, 42'd5);

      // Random phases over counts, idling and stall patterns
      run_phase(11'd1024, 0, 0, 250, 1'b0);
      run_phase(11'd2047, 67, 0, 250, 1'b0);
      run_phase(11'($urandom_range(2, 1023)), 0, 67, 250, 1'b0);
      run_phase(11'd1, 12, 12, 150, 1'b0);
      run_phase(11'd0, 0, 67, 100, 1'b0);
      run_phase(11'd1024, 0, 0, 250, 1'b1);
      settle();

      if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (mirror.pending_results.size() != 0)
            $error("%0d results never arrived", mirror.pending_results.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### weighted_sum_tree_selector_core.f
src/wst_pkg.sv
src/wst_datapath.sv
src/wst_ctrl.sv
src/weighted_sum_tree_selector_core.sv
src/wst_checker.sv
tb/weighted_sum_tree_selector_core_test.sv
